[design/wsc_pkg.sv]
`timescale 1ns / 1ps

package wsc_pkg;

    // Default sizes of the pattern table.
    localparam int MAX_PATTERNS_DEF    = 512;
    localparam int MAX_PATTERN_LEN_DEF = 16;

    localparam int SYM_W  = 8;
    localparam int WAYS_W = 64;

    // Beat kinds on the input side.
    localparam logic [1:0] OP_PATTERN = 2'd0;
    localparam logic [1:0] OP_DESIGN  = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_COUNTED   = 2'd0;
    localparam logic [1:0] ST_SATURATED = 2'd1;
    localparam logic [1:0] ST_STORED    = 2'd2;
    localparam logic [1:0] ST_REJECTED  = 2'd3;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_WAIT = 5'b00100,
        S_FIN  = 5'b01000,
        S_PUT  = 5'b10000
    } seq_state_t;

endpackage

[design/word_segmentation_counter_core.sv]
`timescale 1ns / 1ps

// Counts the ways a design string splits into stored patterns. Patterns are
// loaded one symbol per beat (tuser = 0, tlast on the final symbol) and each
// closing beat returns a stored or rejected status; tuser = 2 clears the
// table. Design symbols arrive with tuser = 1 and the beat with tlast returns
// the count of segmentations, saturated at all ones with status 1 on
// overflow. The closing beat of a pattern goes to S_PUT, which waits for the
// output to be free. A design symbol scans the whole table through the
// single read port of the pattern memory, one pattern per cycle, then waits
// in S_WAIT until the read pipeline drains and closes the position in S_FIN;
// an empty table skips the scan. The closing symbol of a design goes on from
// S_FIN to S_PUT and waits there for the output. The block takes a new
// beat while an earlier result still waits on the output.
module word_segmentation_counter_core #(
    parameter int MAX_PATTERNS    = wsc_pkg::MAX_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = wsc_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol [7:0]
    input  logic [1:0]  s_tuser,   // opcode [1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // ways [63:0]
    output logic [1:0]  m_tuser    // status [1:0]
);

    import wsc_pkg::*;

    localparam int L   = MAX_PATTERN_LEN;
    localparam int P   = MAX_PATTERNS;
    localparam int LW  = $clog2(L + 1);
    localparam int CW  = $clog2(P + 1);
    localparam int AW  = (P > 1) ? $clog2(P) : 1;
    localparam int IW  = (L > 1) ? $clog2(L) : 1;
    localparam int RW  = L * SYM_W + LW;

    seq_state_t state_reg, state_next;

    // Pattern load state.
    logic [SYM_W-1:0] buf_reg [L];
    logic [LW-1:0]    load_len_reg;
    logic             load_ovf_reg;
    logic [CW-1:0]    pat_count_reg;

    // Design state.
    logic [SYM_W-1:0]  hist_reg [L];
    logic [WAYS_W-1:0] win_reg [L];
    logic [LW-1:0]     pos_reg;
    logic              sat_reg;
    logic              dlast_reg;

    // Scan pipeline.
    logic [CW-1:0]     p_reg;
    logic              s1_v_reg;
    logic              s2_v_reg;
    logic              hit_reg;
    logic [WAYS_W-1:0] add_reg;
    logic [WAYS_W-1:0] sum_reg;

    // Pending result.
    logic [WAYS_W-1:0] res_ways_reg;
    logic [1:0]        res_status_reg;
    logic              m_tvalid_reg;
    logic [WAYS_W-1:0] m_ways_reg;
    logic [1:0]        m_status_reg;

    logic              acc;
    logic              out_free;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [RW-1:0]     ram_wdata;
    logic              ram_re;
    logic [RW-1:0]     ram_rdata;
    logic [SYM_W-1:0]  buf_next [L];
    logic [LW-1:0]     len_next;
    logic              ovf_next;
    logic [LW-1:0]     rd_len;
    logic              rd_match;
    logic [IW-1:0]     win_idx;
    logic [WAYS_W:0]   sum_wide;

    assign s_tready = (state_reg == S_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Pattern buffer: newest symbol at place zero, older ones move up.
    always_comb begin
        for (int k = 0; k < L; k++) begin
            buf_next[k] = buf_reg[k];
        end
        len_next = load_len_reg;
        ovf_next = load_ovf_reg;
        if (load_len_reg < LW'(L)) begin
            for (int k = L - 1; k > 0; k--) begin
                buf_next[k] = buf_reg[k-1];
            end
            buf_next[0] = s_tdata;
            len_next    = load_len_reg + 1'b1;
        end else begin
            ovf_next = 1'b1;
        end
    end

    // Table row: length above the reversed symbols.
    always_comb begin
        ram_wdata[RW-1 -: LW] = len_next;
        for (int k = 0; k < L; k++) begin
            ram_wdata[k*SYM_W +: SYM_W] = buf_next[k];
        end
    end

    assign ram_we = acc && (s_tuser == OP_PATTERN) && s_tlast && !ovf_next
                    && (pat_count_reg < CW'(P));
    assign ram_waddr = pat_count_reg[AW-1:0];
    assign ram_re    = (state_reg == S_SCAN);

    wsc_ram #(
        .WIDTH(RW),
        .DEPTH(P)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (p_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Compare one table row against the symbol history.
    assign rd_len  = ram_rdata[RW-1 -: LW];
    assign win_idx = IW'(rd_len - 1'b1);
    always_comb begin
        rd_match = (rd_len != '0) && (rd_len <= pos_reg) && (rd_len <= LW'(L));
        for (int j = 0; j < L; j++) begin
            if ((LW'(j) < rd_len) && (ram_rdata[j*SYM_W +: SYM_W] != hist_reg[j])) begin
                rd_match = 1'b0;
            end
        end
    end

    assign sum_wide = {1'b0, sum_reg} + {1'b0, add_reg};

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (acc && s_tuser == OP_PATTERN && s_tlast) begin
                    state_next = S_PUT;
                end else if (acc && s_tuser == OP_DESIGN) begin
                    state_next = (pat_count_reg == '0) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (p_reg + 1'b1 == pat_count_reg) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!s1_v_reg && !s2_v_reg) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                state_next = dlast_reg ? S_PUT : S_IDLE;
            end
            S_PUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            load_len_reg  <= '0;
            load_ovf_reg  <= 1'b0;
            pat_count_reg <= '0;
            pos_reg       <= '0;
            sat_reg       <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            for (int k = 0; k < L; k++) begin
                win_reg[k] <= (k == 0) ? WAYS_W'(1) : '0;
            end
        end else begin
            state_reg <= state_next;
            s1_v_reg  <= ram_re;
            s2_v_reg  <= s1_v_reg;

            if (acc && s_tuser == OP_PATTERN) begin
                if (s_tlast) begin
                    load_len_reg <= '0;
                    load_ovf_reg <= 1'b0;
                    if (ram_we) begin
                        pat_count_reg <= pat_count_reg + 1'b1;
                    end
                end else begin
                    load_len_reg <= len_next;
                    load_ovf_reg <= ovf_next;
                end
            end else if (acc && s_tuser == OP_CLEAR) begin
                pat_count_reg <= '0;
                load_len_reg  <= '0;
                load_ovf_reg  <= 1'b0;
            end

            if (acc && s_tuser == OP_DESIGN && pos_reg < LW'(L)) begin
                pos_reg <= pos_reg + 1'b1;
            end

            if (s2_v_reg && hit_reg && sum_wide[WAYS_W]) begin
                sat_reg <= 1'b1;
            end

            // Close the position: shift the way counts, restart at design end.
            if (state_reg == S_FIN) begin
                if (dlast_reg) begin
                    for (int k = 0; k < L; k++) begin
                        win_reg[k] <= (k == 0) ? WAYS_W'(1) : '0;
                    end
                    pos_reg <= '0;
                    sat_reg <= 1'b0;
                end else begin
                    for (int k = L - 1; k > 0; k--) begin
                        win_reg[k] <= win_reg[k-1];
                    end
                    win_reg[0] <= sum_reg;
                end
            end

            if (state_reg == S_PUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (acc && s_tuser == OP_PATTERN) begin
            for (int k = 0; k < L; k++) begin
                buf_reg[k] <= buf_next[k];
            end
            res_ways_reg   <= '0;
            res_status_reg <= (ram_we) ? ST_STORED : ST_REJECTED;
        end
        if (acc && s_tuser == OP_DESIGN) begin
            for (int k = L - 1; k > 0; k--) begin
                hist_reg[k] <= hist_reg[k-1];
            end
            hist_reg[0] <= s_tdata;
            dlast_reg   <= s_tlast;
            sum_reg     <= '0;
            p_reg       <= '0;
        end
        if (ram_re) begin
            p_reg <= p_reg + 1'b1;
        end
        if (s1_v_reg) begin
            hit_reg <= rd_match;
            add_reg <= win_reg[win_idx];
        end
        if (s2_v_reg && hit_reg) begin
            sum_reg <= sum_wide[WAYS_W] ? '1 : sum_wide[WAYS_W-1:0];
        end
        if (state_reg == S_FIN && dlast_reg) begin
            res_ways_reg   <= sum_reg;
            res_status_reg <= sat_reg ? ST_SATURATED : ST_COUNTED;
        end
        if (state_reg == S_PUT && out_free) begin
            m_ways_reg   <= res_ways_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_ways_reg;
    assign m_tuser  = m_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pat_count_reg <= CW'(P))
        else $error("pattern count beyond table size");
    a_acc_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_v_reg |-> (state_reg == S_SCAN || state_reg == S_WAIT))
        else $error("accumulation outside a table scan");
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LW'(L))
        else $error("design position beyond window");
    a_put_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUT && out_free) |=> m_tvalid_reg)
        else $error("result not presented");
`endif

endmodule

[design/wsc_ram.sv]
`timescale 1ns / 1ps

module wsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
